[design/pidaw_pkg.sv]
package pidaw_pkg;

    localparam int GAIN_W         = 24;
    localparam int LIM_W          = 15;
    localparam int SAMPLE_W       = 16;
    localparam int ERR_W          = SAMPLE_W + 1;
    localparam int INT_W          = 16;
    localparam int DIFF_W         = ERR_W + 1;
    localparam int DRIVE_W        = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int PROD_W         = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = GAIN_W;

    localparam logic signed [ERR_W-1:0] ANGLE_HALF = ERR_W'(4096);
    localparam logic signed [ERR_W-1:0] ANGLE_TURN = ERR_W'(8192);

    localparam logic [GAIN_W-1:0] GAIN_P_RESET         = GAIN_W'(460800);
    localparam logic [GAIN_W-1:0] GAIN_I_RESET         = GAIN_W'(5120);
    localparam logic [GAIN_W-1:0] GAIN_D_RESET         = GAIN_W'(0);
    localparam logic [LIM_W-1:0]  OUTPUT_LIMIT_RESET   = LIM_W'(25000);
    localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RESET = LIM_W'(5000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_OUTPUT_LIMIT   = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_ANGLE_MODE     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  output_limit;
        logic [LIM_W-1:0]  integral_limit;
        logic              angle_mode;
    } cfg_t;

endpackage

[design/pidaw_cfg.sv]
module pidaw_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pidaw_pkg::cfg_t                  cfg
);
    import pidaw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_GAIN_P:         cfg_next.gain_p         = cfg_wdata;
                REG_GAIN_I:         cfg_next.gain_i         = cfg_wdata;
                REG_GAIN_D:         cfg_next.gain_d         = cfg_wdata;
                REG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_wdata[LIM_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_wdata[LIM_W-1:0];
                REG_ANGLE_MODE:     cfg_next.angle_mode     = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RESET;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RESET;
            cfg_reg.angle_mode     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/pid_step_with_angle_wrap.sv]
// PID step with optional encoder-angle wrap.
// Input channel s_*: one beat per control sample (reference, measured), valid/ready.
// Result channel m_*: one beat per sample carrying the clamped drive value.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle with no wait;
// registers are gain_p, gain_i, gain_d (unsigned Q16.8), output_limit, integral_limit
// and angle_mode. Write them only while no sample is in flight.
// From input beat to result beat the stages are: error and integral update,
// the three gain multiplies, then the sum, floor shift and output clamp.
// Throughput is one sample per cycle if not stalled; the error and integral state
// update in the cycle a sample is accepted, so consecutive samples need no spacing.
// When the receiver holds m_ready low with a result waiting, the whole pipeline
// freezes and s_ready drops; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) clears the previous error, the integral,
// all valid flags and returns the registers to their defaults.
module pid_step_with_angle_wrap (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [pidaw_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [pidaw_pkg::SAMPLE_W-1:0]  s_reference,
    input  logic signed [pidaw_pkg::SAMPLE_W-1:0]  s_measured,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pidaw_pkg::DRIVE_W-1:0]   m_drive
);
    import pidaw_pkg::*;

    cfg_t cfg;

    pidaw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic advance;
    logic accept;

    // controller state
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [INT_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]  prev_err_next;
    logic signed [INT_W-1:0]  integral_next;

    // stage 1: error terms
    logic                     valid_s1_reg;
    logic signed [DIFF_W-1:0] err_s1_reg;
    logic signed [DIFF_W-1:0] int_s1_reg;
    logic signed [DIFF_W-1:0] diff_s1_reg;

    // stage 2: products
    logic                     valid_s2_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_d_reg;

    // stage 3: result
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;

    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W-1:0]  err_fold;
    logic signed [DIFF_W-1:0] int_sum;
    logic signed [DIFF_W-1:0] int_lim;
    logic signed [DIFF_W-1:0] int_clamped;
    logic signed [DIFF_W-1:0] err_diff;

    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  acc_shift;
    logic signed [SUM_W-1:0]  out_lim;
    logic signed [SUM_W-1:0]  out_clamped;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    always_comb begin
        err_raw = ERR_W'(s_reference) - ERR_W'(s_measured);
        err_fold = err_raw;
        // a single fold; exact half turn stays as is
        if (cfg.angle_mode) begin
            if (err_raw > ANGLE_HALF) begin
                err_fold = err_raw - ANGLE_TURN;
            end else if (err_raw < -ANGLE_HALF) begin
                err_fold = err_raw + ANGLE_TURN;
            end
        end

        int_sum = DIFF_W'(integral_reg) + DIFF_W'(err_fold);
        int_lim = DIFF_W'({1'b0, cfg.integral_limit});
        int_clamped = int_sum;
        if (int_sum > int_lim) begin
            int_clamped = int_lim;
        end
        if (int_clamped < -int_lim) begin
            int_clamped = -int_lim;
        end

        err_diff = DIFF_W'(err_fold) - DIFF_W'(prev_err_reg);

        prev_err_next = prev_err_reg;
        integral_next = integral_reg;
        if (accept) begin
            prev_err_next = err_fold;
            integral_next = int_clamped[INT_W-1:0];
        end
    end

    always_comb begin
        acc = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        // floor shift of the Q.8 sum
        acc_shift = acc >>> GAIN_FRAC_BITS;
        out_lim = SUM_W'({1'b0, cfg.output_limit});
        out_clamped = acc_shift;
        if (acc_shift > out_lim) begin
            out_clamped = out_lim;
        end
        if (out_clamped < -out_lim) begin
            out_clamped = -out_lim;
        end
        drive_next = out_clamped[DRIVE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            integral_reg  <= '0;
            valid_s1_reg  <= 1'b0;
            valid_s2_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            prev_err_reg <= prev_err_next;
            integral_reg <= integral_next;
            if (advance) begin
                valid_s1_reg  <= s_valid;
                valid_s2_reg  <= valid_s1_reg;
                out_valid_reg <= valid_s2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            err_s1_reg  <= DIFF_W'(err_fold);
            int_s1_reg  <= int_clamped;
            diff_s1_reg <= err_diff;
            prod_p_reg  <= $signed({1'b0, cfg.gain_p}) * err_s1_reg;
            prod_i_reg  <= $signed({1'b0, cfg.gain_i}) * int_s1_reg;
            prod_d_reg  <= $signed({1'b0, cfg.gain_d}) * diff_s1_reg;
            drive_reg   <= drive_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_drive = drive_reg;

endmodule

[tb/tb_pid_step_with_angle_wrap.sv]
`timescale 1ns / 100ps

module tb_pid_step_with_angle_wrap;
    import pidaw_pkg::*;

    localparam int LATENCY       = 3;
    localparam int SETTLE_CYCLES = LATENCY + 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENT_ITEMS = 75;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [GAIN_W-1:0]          GAIN_MAX   = '1;
    localparam logic [LIM_W-1:0]           LIM_MAX    = '1;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] reference;
        logic [SAMPLE_W-1:0] measured;
    } sample_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]        cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata   = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_reference = '0;
    logic signed [SAMPLE_W-1:0]   s_measured  = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [DRIVE_W-1:0]    m_drive;

    // controller copy: registers, previous error and clamped integral
    cfg_t pid_cfg = {GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                     OUTPUT_LIMIT_RESET, INTEGRAL_LIMIT_RESET, 1'b0};
    logic signed [ERR_W-1:0] prev_err_copy = '0;
    logic signed [INT_W-1:0] integ_acc     = '0;

    sample_t                   pending_samples[$];
    sample_t                   cur_sample;
    logic signed [DRIVE_W-1:0] drive_expect[$];

    int send_idle_pct  = 23;
    int recv_idle_pct  = 66;
    bit hold_off       = 1'b0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    pid_step_with_angle_wrap i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reference (s_reference),
        .s_measured  (s_measured),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive     (m_drive)
    );

    always #1 aclk = ~aclk;

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control step: fold, integrate, weigh, floor shift, clamp
    function automatic logic signed [DRIVE_W-1:0] advance_pid(sample_t smp);
        longint err;
        longint integ;
        longint acc;
        err = longint'($signed(smp.reference)) - longint'($signed(smp.measured));
        if (pid_cfg.angle_mode) begin
            if (err > longint'(ANGLE_HALF)) err -= longint'(ANGLE_TURN);
            else if (err < -longint'(ANGLE_HALF)) err += longint'(ANGLE_TURN);
        end
        integ = clamp_mag(longint'(integ_acc) + err, longint'(pid_cfg.integral_limit));
        acc = longint'(pid_cfg.gain_p) * err
            + longint'(pid_cfg.gain_i) * integ
            + longint'(pid_cfg.gain_d) * (err - longint'(prev_err_copy));
        integ_acc     = INT_W'(integ);
        prev_err_copy = ERR_W'(err);
        return DRIVE_W'(clamp_mag(acc >>> GAIN_FRAC_BITS, longint'(pid_cfg.output_limit)));
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(7))
            0: return '0;
            1: return GAIN_MAX;
            6, 7: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(24'h01FFFF));
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        case ($urandom_range(5))
            0: return '0;
            1: return LIM_MAX;
            default: return LIM_W'($urandom_range(1, 32767));
        endcase
    endfunction

    task automatic push_sample(logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] m);
        sample_t smp;
        smp.reference = r;
        smp.measured  = m;
        pending_samples.push_back(smp);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || drive_expect.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_GAIN_P:         pid_cfg.gain_p         = value;
            REG_GAIN_I:         pid_cfg.gain_i         = value;
            REG_GAIN_D:         pid_cfg.gain_d         = value;
            REG_OUTPUT_LIMIT:   pid_cfg.output_limit   = value[LIM_W-1:0];
            REG_INTEGRAL_LIMIT: pid_cfg.integral_limit = value[LIM_W-1:0];
            REG_ANGLE_MODE:     pid_cfg.angle_mode     = value[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_cfg(cfg_t c);
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_GAIN_D, c.gain_d);
        write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(c.output_limit));
        write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(c.integral_limit));
        write_reg(REG_ANGLE_MODE, CFG_DATA_W'(c.angle_mode));
        end_writes();
    endtask

    // sender: expectation is formed at the accepting edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                drive_expect.push_back(advance_pid(cur_sample));
            end
            if (!s_valid || s_ready) begin
                if (!hold_off && pending_samples.size() != 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    cur_sample   = pending_samples.pop_front();
                    s_valid     <= 1'b1;
                    s_reference <= cur_sample.reference;
                    s_measured  <= cur_sample.measured;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each drive beat against the oldest expectation
    always @(posedge aclk) begin
        logic signed [DRIVE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_expect.size() == 0) begin
                    $display("%0t: unexpected drive beat, expected none, actual %0d",
                             $time, m_drive);
                    mismatch_count++;
                end else begin
                    want = drive_expect.pop_front();
                    if (m_drive !== want) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, want, m_drive);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_pid_step_with_angle_wrap: done, errors");
            $finish;
        end
    end

    initial begin
        cfg_t cfg;
        int   r;
        int   m;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults; full-scale errors push the integral into its clamp
        push_sample(16'sd0, 16'sd0);
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(SAMPLE_MAX, SAMPLE_MAX);
        push_sample(16'sd100, 16'sd37);
        push_sample(-16'sd5, 16'sd20);
        wait_drained();

        // angle fold: exact half turn stays, one past it folds, out-of-turn inputs
        cfg            = pid_cfg;
        cfg.gain_d     = 24'h000280;
        cfg.angle_mode = 1'b1;
        load_cfg(cfg);
        push_sample(16'sd4096, 16'sd0);
        push_sample(16'sd0, 16'sd4096);
        push_sample(16'sd4097, 16'sd0);
        push_sample(16'sd0, 16'sd4097);
        push_sample(16'sd8191, 16'sd0);
        push_sample(16'sd0, 16'sd8191);
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        wait_drained();

        // widest sum: every gain and limit at its top
        cfg = {GAIN_MAX, GAIN_MAX, GAIN_MAX, LIM_MAX, LIM_MAX, 1'b0};
        load_cfg(cfg);
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        push_sample(16'sd0, 16'sd0);
        wait_drained();

        // zero limits written with stray upper bits, spare indexes ignored
        write_reg(REG_OUTPUT_LIMIT, 24'hFF8000);
        write_reg(REG_INTEGRAL_LIMIT, 24'h7F8000);
        write_reg(REG_ANGLE_MODE, 24'hFFFFFE);
        write_reg(REG_SPARE_6, '0);
        write_reg(REG_SPARE_7, 24'h000005);
        end_writes();
        push_sample(SAMPLE_MAX, SAMPLE_MIN);
        push_sample(16'sd123, -16'sd77);
        push_sample(SAMPLE_MIN, SAMPLE_MAX);
        wait_drained();

        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 66 : 0;
            recv_idle_pct = (seg < 2) ? 66 : (seg < 4) ? 23 : 0;
            cfg.gain_p         = rand_gain();
            cfg.gain_i         = rand_gain();
            cfg.gain_d         = rand_gain();
            cfg.output_limit   = rand_limit();
            cfg.integral_limit = rand_limit();
            cfg.angle_mode     = 1'($urandom_range(1));
            load_cfg(cfg);
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                if ($urandom_range(9) < 3) begin
                    r = $urandom;
                    m = $urandom;
                end else if (cfg.angle_mode) begin
                    r = $urandom_range(8191);
                    m = $urandom_range(8191);
                end else begin
                    // tracking-like: reference close to the measurement
                    m = $urandom_range(65535) - 32768;
                    r = m + $urandom_range(600) - 300;
                end
                push_sample(SAMPLE_W'(r), SAMPLE_W'(m));
            end
            if (seg == 1) begin
                while (pending_samples.size() > SEGMENT_ITEMS / 2) @(negedge aclk);
                hold_off = 1'b1;
                while (s_valid || drive_expect.size() != 0) @(negedge aclk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("tb_pid_step_with_angle_wrap: done, clean");
        end else begin
            $display("tb_pid_step_with_angle_wrap: done, errors");
        end
        $finish;
    end

endmodule

[pid_step_with_angle_wrap.f]
design/pidaw_pkg.sv
design/pidaw_cfg.sv
design/pid_step_with_angle_wrap.sv
tb/tb_pid_step_with_angle_wrap.sv
